### sv/gbca_pkg.sv
package gbca_pkg;

  // Field widths of the stream items
  localparam int KIND_W    = 2;
  localparam int GRP_W     = 8;
  localparam int SLOT_W    = 4;
  localparam int AGT_W     = 10;
  localparam int OPN_W     = 17;
  localparam int GS_W      = 5;
  localparam int CFG_IDX_W = 2;
  localparam int MOD_W     = 17;
  // Sum of up to sixteen Q1.16 opinions
  localparam int SUM_W     = 21;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  localparam logic [OPN_W-1:0] ONE_Q16 = 17'h10000;

  // Entries in the queue between front and back end
  localparam int QDEPTH = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON    = 2'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_GROUP = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GATHER,
    ST_DECIDE,
    ST_DIVIDE,
    ST_REPORT
  } state_t;

  // Classified item as it travels through the queue
  typedef struct packed {
    kind_t             kind;
    logic [GRP_W-1:0]  grp;        // group index reduced to the group count
    logic [SLOT_W-1:0] slot;
    logic              slot_ok;    // slot lies inside the group
    logic [AGT_W-1:0]  agent;      // agent index as received
    logic [AGT_W-1:0]  agent_red;  // agent index reduced to the agent count
    logic [OPN_W-1:0]  value;      // opinion saturated to one
  } cmd_t;

  // One result item
  typedef struct packed {
    logic [AGT_W-1:0] agent;
    logic [OPN_W-1:0] opinion;
    logic             averaged;
    logic             last;
  } res_t;

  // Request to the serial divider
  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [GS_W-1:0]  divisor;
  } div_req_t;

  // x mod m for a narrow x by restoring reduction, one shifted compare per bit
  function automatic logic [AGT_W-1:0] reduce_mod(input logic [AGT_W-1:0] x,
                                                  input logic [MOD_W-1:0] m);
    logic [AGT_W+MOD_W-1:0] r;
    logic [AGT_W+MOD_W-1:0] d;
    r = (AGT_W+MOD_W)'(x);
    for (int k = AGT_W - 1; k >= 0; k--) begin
      d = (AGT_W+MOD_W)'(m) << k;
      if (r >= d) begin
        r = r - d;
      end
    end
    return r[AGT_W-1:0];
  endfunction

endpackage

### sv/gbca_front.sv
module gbca_front #(
  parameter int AGENTS      = 1024,
  parameter int GROUPS      = 256,
  parameter int MEMBERS_MAX = 4
) (
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // group_index[7:0], slot[11:8], agent_index[21:12], opinion_value[38:22]
  input  logic [gbca_pkg::IN_DATA_W-1:0]   in_tdata,
  // kind[1:0]
  input  logic [gbca_pkg::KIND_W-1:0]      in_tuser,
  output logic                             push_valid,
  input  logic                             push_ready,
  output gbca_pkg::cmd_t                   push_cmd
);

  localparam logic [gbca_pkg::MOD_W-1:0] AGT_MOD = gbca_pkg::MOD_W'(AGENTS);
  localparam logic [gbca_pkg::MOD_W-1:0] GRP_MOD = gbca_pkg::MOD_W'(GROUPS);

  logic [gbca_pkg::GRP_W-1:0]  grp_raw;
  logic [gbca_pkg::SLOT_W-1:0] slot_raw;
  logic [gbca_pkg::AGT_W-1:0]  agent_raw;
  logic [gbca_pkg::OPN_W-1:0]  value_raw;

  // Unpack the item fields
  assign grp_raw   = in_tdata[7:0];
  assign slot_raw  = in_tdata[11:8];
  assign agent_raw = in_tdata[21:12];
  assign value_raw = in_tdata[38:22];

  // Classify: reduce indices, check the slot, saturate the opinion
  always_comb begin
    push_cmd.kind      = gbca_pkg::kind_t'(in_tuser);
    push_cmd.grp       = gbca_pkg::GRP_W'(gbca_pkg::reduce_mod(
                           gbca_pkg::AGT_W'(grp_raw), GRP_MOD));
    push_cmd.slot      = slot_raw;
    push_cmd.slot_ok   = (32'(slot_raw) < MEMBERS_MAX);
    push_cmd.agent     = agent_raw;
    push_cmd.agent_red = gbca_pkg::reduce_mod(agent_raw, AGT_MOD);
    push_cmd.value     = (value_raw > gbca_pkg::ONE_Q16) ? gbca_pkg::ONE_Q16 : value_raw;
  end

  assign push_valid = in_tvalid;
  assign in_tready  = push_ready;

endmodule

### sv/gbca_queue.sv
module gbca_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  gbca_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output gbca_pkg::cmd_t pop_cmd
);

  localparam int PW = (gbca_pkg::QDEPTH > 1) ? $clog2(gbca_pkg::QDEPTH) : 1;
  localparam int CNT_W = $clog2(gbca_pkg::QDEPTH + 1);

  gbca_pkg::cmd_t   entry_r [gbca_pkg::QDEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign push_ready = (count_r != CNT_W'(gbca_pkg::QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = entry_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(gbca_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(gbca_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### sv/gbca_div.sv
module gbca_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  gbca_pkg::div_req_t           req,
  output logic                         busy,
  output logic [gbca_pkg::SUM_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(gbca_pkg::SUM_W + 1);

  logic [CNT_W-1:0]              cnt_r;
  logic [gbca_pkg::SUM_W-1:0]    dq_r, dq_nxt;
  logic [gbca_pkg::GS_W-1:0]     rem_r, rem_nxt;
  logic [gbca_pkg::GS_W-1:0]     dvs_r;
  logic [gbca_pkg::GS_W:0]       trial;

  assign busy     = (cnt_r != '0);
  assign quotient = dq_r;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_r, dq_r[gbca_pkg::SUM_W-1]};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = gbca_pkg::GS_W'(trial - {1'b0, dvs_r});
      dq_nxt  = {dq_r[gbca_pkg::SUM_W-2:0], 1'b1};
    end else begin
      rem_nxt = gbca_pkg::GS_W'(trial);
      dq_nxt  = {dq_r[gbca_pkg::SUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (req.start) begin
      cnt_r <= CNT_W'(gbca_pkg::SUM_W);
    end else if (busy) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dq_r  <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy) begin
      dq_r  <= dq_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

### sv/gbca_back.sv
module gbca_back #(
  parameter int AGENTS      = 1024,
  parameter int GROUPS      = 256,
  parameter int MEMBERS_MAX = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  gbca_pkg::cmd_t                cmd,
  input  logic [gbca_pkg::GS_W-1:0]     group_size,
  input  logic [gbca_pkg::OPN_W-1:0]    epsilon,
  output logic                          out_valid,
  input  logic                          out_ready,
  output gbca_pkg::res_t                out_res
);

  localparam int AGT_SPAN   = 1 << gbca_pkg::AGT_W;
  localparam int GRP_SPAN   = 1 << gbca_pkg::GRP_W;
  localparam int OPN_DEPTH  = (AGENTS < AGT_SPAN) ? AGENTS : AGT_SPAN;
  localparam int MEM_GROUPS = (GROUPS < GRP_SPAN) ? GROUPS : GRP_SPAN;
  localparam int MDEPTH     = MEM_GROUPS * MEMBERS_MAX;
  localparam int AW         = $clog2(OPN_DEPTH);
  localparam int MAW        = $clog2(MDEPTH);
  localparam int CW         = $clog2(MEMBERS_MAX + 1);
  localparam int IW         = $clog2(MEMBERS_MAX);
  localparam logic [gbca_pkg::MOD_W-1:0] AGT_MOD = gbca_pkg::MOD_W'(AGENTS);

  // Memories
  logic [gbca_pkg::OPN_W-1:0] opn_mem [OPN_DEPTH];
  logic [gbca_pkg::AGT_W-1:0] mbr_mem [MDEPTH];

  logic                       opn_we;
  logic [AW-1:0]              opn_wa, opn_ra;
  logic [gbca_pkg::OPN_W-1:0] opn_wd, opn_q_r;
  logic                       mbr_we;
  logic [MAW-1:0]             mbr_wa, mbr_ra;
  logic [gbca_pkg::AGT_W-1:0] mbr_q_r;

  // Sequencer state
  gbca_pkg::state_t           state_r, state_nxt;
  logic [MAW-1:0]             base_r, base_nxt;
  logic [CW-1:0]              n_r, n_nxt, n_eff;
  logic [CW-1:0]              iss_r, iss_nxt;
  logic [CW-1:0]              acc_r, acc_nxt;
  logic [CW-1:0]              rep_r, rep_nxt;
  logic                       v1_r, v1_nxt;
  logic                       v2_r, v2_nxt;
  logic [gbca_pkg::AGT_W-1:0] id2_r, id2_nxt;
  logic [gbca_pkg::OPN_W-1:0] max_r, max_nxt;
  logic [gbca_pkg::OPN_W-1:0] min_r, min_nxt;
  logic [gbca_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic                       avg_r, avg_nxt;
  logic                       acc_we;

  // Per-member gather results
  logic [gbca_pkg::AGT_W-1:0] ids_r [MEMBERS_MAX];
  logic [gbca_pkg::OPN_W-1:0] xs_r  [MEMBERS_MAX];

  // Output register
  logic                       out_valid_r;
  gbca_pkg::res_t             out_res_r, res_nxt;
  logic                       out_load, out_free;

  // Divider
  gbca_pkg::div_req_t         div_req;
  logic                       div_busy;
  logic [gbca_pkg::SUM_W-1:0] div_q;

  logic                       take, gather_done, in_bound, rep_last;
  logic [gbca_pkg::OPN_W-1:0] spread;
  logic [IW-1:0]              acc_idx, rep_idx;

  assign out_free    = !out_valid_r || out_ready;
  assign take        = pop_valid && pop_ready;
  assign gather_done = v2_r && (acc_r == n_r - CW'(1));
  assign spread      = max_r - min_r;
  assign in_bound    = (spread < epsilon);
  assign rep_last    = (rep_r == n_r - CW'(1));
  assign acc_idx     = acc_r[IW-1:0];
  assign rep_idx     = rep_r[IW-1:0];
  assign out_valid   = out_valid_r;
  assign out_res     = out_res_r;

  // Members in use, clamped to one and to the slot count
  always_comb begin
    if (group_size == '0) begin
      n_eff = CW'(1);
    end else if (32'(group_size) > MEMBERS_MAX) begin
      n_eff = CW'(MEMBERS_MAX);
    end else begin
      n_eff = CW'(group_size);
    end
  end

  gbca_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gbca_pkg::ST_IDLE: begin
        if (take && cmd.kind == gbca_pkg::KIND_GROUP) begin
          state_nxt = gbca_pkg::ST_GATHER;
        end
      end
      gbca_pkg::ST_GATHER: begin
        if (gather_done) begin
          state_nxt = gbca_pkg::ST_DECIDE;
        end
      end
      gbca_pkg::ST_DECIDE: begin
        state_nxt = in_bound ? gbca_pkg::ST_DIVIDE : gbca_pkg::ST_REPORT;
      end
      gbca_pkg::ST_DIVIDE: begin
        if (!div_busy) begin
          state_nxt = gbca_pkg::ST_REPORT;
        end
      end
      gbca_pkg::ST_REPORT: begin
        if (out_free && rep_last) begin
          state_nxt = gbca_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gbca_pkg::ST_IDLE;
    endcase
  end

  // Outputs, memory controls and datapath updates
  always_comb begin
    pop_ready        = 1'b0;
    out_load         = 1'b0;
    res_nxt          = '0;
    mbr_we           = 1'b0;
    mbr_wa           = MAW'(32'(cmd.grp) * MEMBERS_MAX + 32'(cmd.slot));
    mbr_ra           = base_r + MAW'(iss_r);
    opn_we           = 1'b0;
    opn_wa           = AW'(cmd.agent_red);
    opn_wd           = cmd.value;
    opn_ra           = AW'(gbca_pkg::reduce_mod(mbr_q_r, AGT_MOD));
    div_req.start    = 1'b0;
    div_req.dividend = sum_r;
    div_req.divisor  = gbca_pkg::GS_W'(n_r);
    base_nxt         = base_r;
    n_nxt            = n_r;
    iss_nxt          = iss_r;
    acc_nxt          = acc_r;
    rep_nxt          = rep_r;
    v1_nxt           = 1'b0;
    v2_nxt           = 1'b0;
    id2_nxt          = id2_r;
    max_nxt          = max_r;
    min_nxt          = min_r;
    sum_nxt          = sum_r;
    avg_nxt          = avg_r;
    acc_we           = 1'b0;

    case (state_r)
      gbca_pkg::ST_IDLE: begin
        pop_ready = out_free;
        if (take) begin
          res_nxt.agent = cmd.agent;
          res_nxt.last  = 1'b1;
          case (cmd.kind)
            gbca_pkg::KIND_LOAD: begin
              mbr_we   = cmd.slot_ok;
              out_load = 1'b1;
            end
            gbca_pkg::KIND_WRITE: begin
              opn_we          = 1'b1;
              out_load        = 1'b1;
              res_nxt.opinion = cmd.value;
            end
            gbca_pkg::KIND_GROUP: begin
              base_nxt = MAW'(32'(cmd.grp) * MEMBERS_MAX);
              n_nxt    = n_eff;
              iss_nxt  = '0;
              acc_nxt  = '0;
              rep_nxt  = '0;
              max_nxt  = '0;
              min_nxt  = gbca_pkg::ONE_Q16;
              sum_nxt  = '0;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end

      // Three-deep pipe: slot read, opinion read, accumulate
      gbca_pkg::ST_GATHER: begin
        if (iss_r < n_r) begin
          v1_nxt  = 1'b1;
          iss_nxt = iss_r + CW'(1);
        end
        v2_nxt = v1_r;
        if (v1_r) begin
          id2_nxt = mbr_q_r;
        end
        if (v2_r) begin
          acc_we  = 1'b1;
          acc_nxt = acc_r + CW'(1);
          max_nxt = (opn_q_r > max_r) ? opn_q_r : max_r;
          min_nxt = (opn_q_r < min_r) ? opn_q_r : min_r;
          sum_nxt = sum_r + gbca_pkg::SUM_W'(opn_q_r);
        end
      end

      gbca_pkg::ST_DECIDE: begin
        avg_nxt       = in_bound;
        div_req.start = in_bound;
      end

      gbca_pkg::ST_DIVIDE: begin
      end

      // Report one member a cycle while the output is free, writing back the mean when averaging
      gbca_pkg::ST_REPORT: begin
        if (out_free) begin
          out_load         = 1'b1;
          res_nxt.agent    = ids_r[rep_idx];
          res_nxt.opinion  = avg_r ? gbca_pkg::OPN_W'(div_q) : xs_r[rep_idx];
          res_nxt.averaged = avg_r;
          res_nxt.last     = rep_last;
          opn_we           = avg_r;
          opn_wa           = AW'(gbca_pkg::reduce_mod(ids_r[rep_idx], AGT_MOD));
          opn_wd           = gbca_pkg::OPN_W'(div_q);
          rep_nxt          = rep_r + CW'(1);
        end
      end

      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gbca_pkg::ST_IDLE;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= v1_nxt;
      v2_r    <= v2_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    n_r    <= n_nxt;
    iss_r  <= iss_nxt;
    acc_r  <= acc_nxt;
    rep_r  <= rep_nxt;
    id2_r  <= id2_nxt;
    max_r  <= max_nxt;
    min_r  <= min_nxt;
    sum_r  <= sum_nxt;
    avg_r  <= avg_nxt;
    if (acc_we) begin
      ids_r[acc_idx] <= id2_r;
      xs_r[acc_idx]  <= opn_q_r;
    end
    if (out_load) begin
      out_res_r <= res_nxt;
    end
  end

  // Opinion memory
  always_ff @(posedge clk) begin
    if (opn_we) begin
      opn_mem[opn_wa] <= opn_wd;
    end
    opn_q_r <= opn_mem[opn_ra];
  end

  // Membership memory
  always_ff @(posedge clk) begin
    if (mbr_we) begin
      mbr_mem[mbr_wa] <= cmd.agent;
    end
    mbr_q_r <= mbr_mem[mbr_ra];
  end

endmodule

### sv/group_bounded_confidence_average_unit.sv
// Bounded-confidence averaging over agent groups. A front end takes items and
// classifies them into a two-entry queue; a back end holds the opinion and
// membership memories and executes one item at a time. A membership load,
// an opinion write or an unused kind yields one acknowledgement through the
// output register once the back end takes it. A group interaction streams
// the slots of its members in use and their opinions through the two
// registered memory reads, tests the spread, and then reports the members
// one per cycle while the output is free, writing the mean back over the
// single opinion write port when the group averages. The mean then comes
// from a bit-serial divider.
// Memory contents are not cleared at reset; entries are valid once written.
module group_bounded_confidence_average_unit #(
  parameter int AGENTS      = 1024,
  parameter int GROUPS      = 256,
  parameter int MEMBERS_MAX = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input items
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // group_index[7:0], slot[11:8], agent_index[21:12], opinion_value[38:22]
  input  logic [gbca_pkg::IN_DATA_W-1:0]   in_tdata,
  // kind[1:0]
  input  logic [gbca_pkg::KIND_W-1:0]      in_tuser,
  // Result items
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // member_agent[9:0], member_opinion[26:10]
  output logic [gbca_pkg::OUT_DATA_W-1:0]  out_tdata,
  // averaged[0]
  output logic                             out_tuser,
  output logic                             out_tlast,
  // Configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gbca_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gbca_pkg::OPN_W-1:0]       cfg_data
);

  logic [gbca_pkg::GS_W-1:0]  group_size_r;
  logic [gbca_pkg::OPN_W-1:0] epsilon_r;

  logic           push_valid, push_ready;
  gbca_pkg::cmd_t push_cmd;
  logic           pop_valid, pop_ready;
  gbca_pkg::cmd_t pop_cmd;
  logic           res_valid;
  gbca_pkg::res_t res;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_size_r <= gbca_pkg::GS_W'(4);
      epsilon_r    <= gbca_pkg::OPN_W'(16384);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gbca_pkg::CFG_GROUP_SIZE: group_size_r <= cfg_data[gbca_pkg::GS_W-1:0];
        gbca_pkg::CFG_EPSILON:    epsilon_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  gbca_front #(
    .AGENTS      (AGENTS),
    .GROUPS      (GROUPS),
    .MEMBERS_MAX (MEMBERS_MAX)
  ) u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  gbca_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  gbca_back #(
    .AGENTS      (AGENTS),
    .GROUPS      (GROUPS),
    .MEMBERS_MAX (MEMBERS_MAX)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .cmd        (pop_cmd),
    .group_size (group_size_r),
    .epsilon    (epsilon_r),
    .out_valid  (res_valid),
    .out_ready  (out_tready),
    .out_res    (res)
  );

  // Pack the result item
  assign out_tvalid = res_valid;
  assign out_tdata  = {5'b0, res.opinion, res.agent};
  assign out_tuser  = res.averaged;
  assign out_tlast  = res.last;

endmodule

### sv/gbca_checker.sv
module gbca_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // No result is offered right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // Members of a group follow each other without a gap
  a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap inside a group report");

  // Averaged members all carry the same mean
  a_avg_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser && !out_tlast |=>
    out_tuser && (out_tdata[26:10] == $past(out_tdata[26:10])))
    else $error("averaged group reported differing opinions");

endmodule

bind group_bounded_confidence_average_unit gbca_checker u_gbca_checker (.*);
